// ===== rtl/sdtq_pkg.sv =====
package sdtq_pkg;

    localparam int DEADLINE_W = 64;
    localparam int STATUS_W   = 2;

    // action codes
    localparam logic ACT_INSERT = 1'b0;
    localparam logic ACT_EXPIRE = 1'b1;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

endpackage

// ===== rtl/sdtq_req_if.sv =====
interface sdtq_req_if #(
    parameter int TAG_WIDTH = 16
);
    logic                                 valid;
    logic                                 ready;
    logic                                 action;
    logic [sdtq_pkg::DEADLINE_W-1:0]      deadline;
    logic [TAG_WIDTH-1:0]                 payload_tag;
    logic [sdtq_pkg::DEADLINE_W-1:0]      counter_now;

    modport source (output valid, action, deadline, payload_tag, counter_now, input ready);
    modport sink   (input valid, action, deadline, payload_tag, counter_now, output ready);
endinterface

// ===== rtl/sdtq_rsp_if.sv =====
interface sdtq_rsp_if #(
    parameter int TAG_WIDTH   = 16,
    parameter int COUNT_WIDTH = 5
);
    logic                                 valid;
    logic                                 ready;
    logic [sdtq_pkg::STATUS_W-1:0]        status;
    logic                                 popped_valid;
    logic [TAG_WIDTH-1:0]                 popped_tag;
    logic                                 timer_enable;
    logic [sdtq_pkg::DEADLINE_W-1:0]      timer_reload;
    logic [sdtq_pkg::DEADLINE_W-1:0]      head_deadline;
    logic [COUNT_WIDTH-1:0]               occupancy;

    modport source (output valid, status, popped_valid, popped_tag, timer_enable,
                    timer_reload, head_deadline, occupancy, input ready);
    modport sink   (input valid, status, popped_valid, popped_tag, timer_enable,
                    timer_reload, head_deadline, occupancy, output ready);
endinterface

// ===== rtl/sorted_deadline_timer_queue.sv =====
// Sorted deadline timer queue. Holds up to QUEUE_DEPTH (deadline, tag) events in
// deadline order, ties first-in first-out, in one RAM used as a ring with a head
// pointer; the head entry is also kept in registers. Each beat on req is either an
// insert or an expire, and gives exactly one beat on rsp with the status, the popped
// tag and the timer state after the step. A refused insert, an insert into an empty
// queue, an expire on an empty queue or an expire of the last entry goes straight to
// the response state after accept; an expire that leaves entries first refetches
// the new head from the RAM; an insert into a non-empty queue walks the ring from
// the tail, one entry per cycle through the RAM read/write ports. One item is worked
// on at a time, so the next beat is taken no sooner than the cycle after the result
// loads; a finished result waits in the output register while the next beat is taken.
module sorted_deadline_timer_queue #(
    parameter int QUEUE_DEPTH = 16,
    parameter int TAG_WIDTH   = 16
) (
    input logic        clk,
    input logic        rst_n,
    sdtq_req_if.sink   req,
    sdtq_rsp_if.source rsp
);

    localparam int PW      = $clog2(QUEUE_DEPTH);
    localparam int CW      = $clog2(QUEUE_DEPTH + 1);
    localparam int DW      = sdtq_pkg::DEADLINE_W;
    localparam int ENTRY_W = DW + TAG_WIDTH;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_SCAN  = 5'b00010,
        S_PLACE = 5'b00100,
        S_POPRD = 5'b01000,
        S_RESP  = 5'b10000
    } state_t;

    // logical place to ring address
    function automatic logic [PW-1:0] phys(input logic [PW-1:0] base, input logic [CW-1:0] x);
        logic [CW:0] s;
        s = (CW+1)'(base) + (CW+1)'(x);
        if (s >= (CW+1)'(QUEUE_DEPTH))
        begin
            s = s - (CW+1)'(QUEUE_DEPTH);
        end
        return s[PW-1:0];
    endfunction

    state_t                        state_reg, state_next;
    logic [CW-1:0]                 count_reg, count_next;
    logic [PW-1:0]                 head_ptr_reg, head_ptr_next;
    logic [CW-1:0]                 cur_reg, cur_next;
    logic [DW-1:0]                 head_dl_reg, head_dl_next;
    logic [TAG_WIDTH-1:0]          head_tag_reg, head_tag_next;
    logic [DW-1:0]                 dl_reg, dl_next;
    logic [TAG_WIDTH-1:0]          tag_reg, tag_next;
    logic [DW-1:0]                 now_reg, now_next;
    logic [sdtq_pkg::STATUS_W-1:0] st_reg, st_next;
    logic                          pv_reg, pv_next;
    logic [TAG_WIDTH-1:0]          ptag_reg, ptag_next;

    logic                          out_valid_reg;
    logic [sdtq_pkg::STATUS_W-1:0] out_status_reg;
    logic                          out_pv_reg;
    logic [TAG_WIDTH-1:0]          out_ptag_reg;
    logic                          out_en_reg;
    logic [DW-1:0]                 out_reload_reg;
    logic [DW-1:0]                 out_head_reg;
    logic [CW-1:0]                 out_count_reg;

    logic                          ram_we;
    logic [PW-1:0]                 ram_waddr;
    logic [ENTRY_W-1:0]            ram_wdata;
    logic [PW-1:0]                 ram_raddr;
    logic [ENTRY_W-1:0]            ram_rdata;
    logic [DW-1:0]                 rd_dl;

    logic                          accept;
    logic                          out_free;
    logic                          resp_load;

    assign accept    = req.valid && req.ready;
    assign out_free  = !out_valid_reg || rsp.ready;
    assign resp_load = (state_reg == S_RESP) && out_free;
    assign rd_dl     = ram_rdata[ENTRY_W-1:TAG_WIDTH];
    assign req.ready = (state_reg == S_IDLE);

    // entry store
    sdtq_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // sequencer: accept, tail walk for insert, head refetch for expire
    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        head_ptr_next = head_ptr_reg;
        cur_next      = cur_reg;
        head_dl_next  = head_dl_reg;
        head_tag_next = head_tag_reg;
        dl_next       = dl_reg;
        tag_next      = tag_reg;
        now_next      = now_reg;
        st_next       = st_reg;
        pv_next       = pv_reg;
        ptag_next     = ptag_reg;
        ram_we        = 1'b0;
        ram_waddr     = phys(head_ptr_reg, cur_reg);
        ram_wdata     = {dl_reg, tag_reg};
        ram_raddr     = head_ptr_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    dl_next   = req.deadline;
                    tag_next  = req.payload_tag;
                    now_next  = req.counter_now;
                    st_next   = sdtq_pkg::ST_OK;
                    pv_next   = 1'b0;
                    ptag_next = '0;
                    state_next = S_RESP;
                    if (req.action == sdtq_pkg::ACT_INSERT)
                    begin
                        if (count_reg >= CW'(QUEUE_DEPTH))
                        begin
                            st_next = sdtq_pkg::ST_FULL;
                        end
                        else if (count_reg == '0)
                        begin
                            ram_we        = 1'b1;
                            ram_waddr     = head_ptr_reg;
                            ram_wdata     = {req.deadline, req.payload_tag};
                            head_dl_next  = req.deadline;
                            head_tag_next = req.payload_tag;
                            count_next    = CW'(1);
                        end
                        else
                        begin
                            ram_raddr  = phys(head_ptr_reg, count_reg - CW'(1));
                            cur_next   = count_reg;
                            state_next = S_SCAN;
                        end
                    end
                    else
                    begin
                        if (count_reg == '0)
                        begin
                            st_next = sdtq_pkg::ST_EMPTY;
                        end
                        else
                        begin
                            pv_next       = 1'b1;
                            ptag_next     = head_tag_reg;
                            head_ptr_next = phys(head_ptr_reg, CW'(1));
                            count_next    = count_reg - CW'(1);
                            if (count_reg != CW'(1))
                            begin
                                ram_raddr  = phys(head_ptr_reg, CW'(1));
                                state_next = S_POPRD;
                            end
                        end
                    end
                end
            end
            S_SCAN:
            begin
                // entry at cur-1 is on the read port; the hole sits at cur
                ram_we = 1'b1;
                if (rd_dl > dl_reg)
                begin
                    ram_wdata = ram_rdata;
                    cur_next  = cur_reg - CW'(1);
                    if (cur_reg == CW'(1))
                    begin
                        state_next = S_PLACE;
                    end
                    else
                    begin
                        ram_raddr = phys(head_ptr_reg, cur_reg - CW'(2));
                    end
                end
                else
                begin
                    count_next = count_reg + CW'(1);
                    state_next = S_RESP;
                end
            end
            S_PLACE:
            begin
                // new event becomes the head
                ram_we        = 1'b1;
                head_dl_next  = dl_reg;
                head_tag_next = tag_reg;
                count_next    = count_reg + CW'(1);
                state_next    = S_RESP;
            end
            S_POPRD:
            begin
                head_dl_next  = rd_dl;
                head_tag_next = ram_rdata[TAG_WIDTH-1:0];
                state_next    = S_RESP;
            end
            S_RESP:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            head_ptr_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            head_ptr_reg <= head_ptr_next;
            if (resp_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // working payload and result register
    always_ff @(posedge clk)
    begin
        cur_reg      <= cur_next;
        head_dl_reg  <= head_dl_next;
        head_tag_reg <= head_tag_next;
        dl_reg       <= dl_next;
        tag_reg      <= tag_next;
        now_reg      <= now_next;
        st_reg       <= st_next;
        pv_reg       <= pv_next;
        ptag_reg     <= ptag_next;
        if (resp_load)
        begin
            out_status_reg <= st_reg;
            out_pv_reg     <= pv_reg;
            out_ptag_reg   <= ptag_reg;
            out_count_reg  <= count_reg;
            out_en_reg     <= (count_reg != '0);
            out_head_reg   <= (count_reg != '0) ? head_dl_reg : '0;
            out_reload_reg <= (count_reg != '0) ? (head_dl_reg - now_reg) : '0;
        end
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.status        = out_status_reg;
    assign rsp.popped_valid  = out_pv_reg;
    assign rsp.popped_tag    = out_ptag_reg;
    assign rsp.timer_enable  = out_en_reg;
    assign rsp.timer_reload  = out_reload_reg;
    assign rsp.head_deadline = out_head_reg;
    assign rsp.occupancy     = out_count_reg;

endmodule

// ===== rtl/sdtq_ram.sv =====
module sdtq_ram #(
    parameter int WIDTH = 80,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== tb/sv/sdtq_tb_if.sv =====
// no extra interfaces needed; channel interfaces come from the rtl folder
package sdtq_tb_pkg;

    import sdtq_pkg::*;

    // one request beat as queued for the driver
    typedef struct packed {
        logic        action;
        logic [63:0] deadline;
        logic [15:0] payload_tag;
        logic [63:0] counter_now;
    } timer_req_t;

    // one response beat as predicted
    typedef struct packed {
        logic [1:0]  status;
        logic        popped_valid;
        logic [15:0] popped_tag;
        logic        timer_enable;
        logic [63:0] timer_reload;
        logic [63:0] head_deadline;
        logic [4:0]  occupancy;
    } timer_rsp_t;

endpackage

// ===== tb/sv/testbench.sv =====
module testbench;

    import sdtq_pkg::*;
    import sdtq_tb_pkg::*;

    localparam int DEPTH = 16;

    logic clk;
    logic rst_n;

    sdtq_req_if #(.TAG_WIDTH(16)) req ();
    sdtq_rsp_if #(.TAG_WIDTH(16), .COUNT_WIDTH(5)) rsp ();

    sorted_deadline_timer_queue #(.QUEUE_DEPTH(DEPTH), .TAG_WIDTH(16)) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req.sink),
        .rsp   (rsp.source)
    );

    timer_req_t pending_beats[$];
    timer_rsp_t expected_rsps[$];
    logic [63:0] model_deadlines[$];
    logic [15:0] model_tags[$];
    int errors;
    int send_gap;
    int recv_gap;
    bit hold_sender;

    // clock and reset
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
    end

    // sorted queue model; returns the expected response for one beat
    function automatic timer_rsp_t predict_timer(timer_req_t b);
        timer_rsp_t r;
        int pos;
        r = '0;
        if (b.action == ACT_INSERT)
        begin
            if (model_deadlines.size() >= DEPTH)
                r.status = ST_FULL;
            else
            begin
                pos = 0;
                while (pos < model_deadlines.size() && model_deadlines[pos] <= b.deadline)
                    pos++;
                model_deadlines.insert(pos, b.deadline);
                model_tags.insert(pos, b.payload_tag);
            end
        end
        else
        begin
            if (model_deadlines.size() == 0)
                r.status = ST_EMPTY;
            else
            begin
                r.popped_valid = 1'b1;
                r.popped_tag = model_tags.pop_front();
                void'(model_deadlines.pop_front());
            end
        end
        if (model_deadlines.size() > 0)
        begin
            r.timer_enable = 1'b1;
            r.head_deadline = model_deadlines[0];
            r.timer_reload = model_deadlines[0] - b.counter_now;
        end
        r.occupancy = 5'(model_deadlines.size());
        return r;
    endfunction

    function automatic int pick_gap();
        int p;
        p = $urandom_range(0, 99);
        if (p < 50) return 0;
        if (p < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // driver: one beat at a time from the pending queue
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req.valid <= 1'b0;
            req.action <= ACT_INSERT;
            req.deadline <= '0;
            req.payload_tag <= '0;
            req.counter_now <= '0;
            send_gap <= 0;
        end
        else
        begin
            if (req.valid && req.ready)
                expected_rsps.push_back(predict_timer({req.action, req.deadline,
                                                       req.payload_tag, req.counter_now}));
            if (!req.valid || req.ready)
            begin
                if (send_gap > 0)
                begin
                    send_gap <= send_gap - 1;
                    req.valid <= 1'b0;
                end
                else if (pending_beats.size() > 0 && !hold_sender)
                begin
                    timer_req_t b;
                    b = pending_beats.pop_front();
                    req.valid <= 1'b1;
                    req.action <= b.action;
                    req.deadline <= b.deadline;
                    req.payload_tag <= b.payload_tag;
                    req.counter_now <= b.counter_now;
                    send_gap <= pick_gap();
                end
                else
                    req.valid <= 1'b0;
            end
        end
    end

    // monitor: checks each response beat against the oldest prediction
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp.ready <= 1'b0;
            recv_gap <= 0;
        end
        else
        begin
            if (rsp.valid && rsp.ready)
            begin
                if (expected_rsps.size() == 0)
                begin
                    $error("response beat with nothing expected");
                    errors++;
                end
                else
                begin
                    timer_rsp_t e;
                    e = expected_rsps.pop_front();
                    if (rsp.status !== e.status)
                    begin
                        $error("status: expected %0d, got %0d", e.status, rsp.status);
                        errors++;
                    end
                    if (rsp.popped_valid !== e.popped_valid)
                    begin
                        $error("popped_valid: expected %0d, got %0d", e.popped_valid,
                               rsp.popped_valid);
                        errors++;
                    end
                    if (rsp.popped_tag !== e.popped_tag)
                    begin
                        $error("popped_tag: expected %h, got %h", e.popped_tag, rsp.popped_tag);
                        errors++;
                    end
                    if (rsp.timer_enable !== e.timer_enable)
                    begin
                        $error("timer_enable: expected %0d, got %0d", e.timer_enable,
                               rsp.timer_enable);
                        errors++;
                    end
                    if (rsp.timer_reload !== e.timer_reload)
                    begin
                        $error("timer_reload: expected %h, got %h", e.timer_reload,
                               rsp.timer_reload);
                        errors++;
                    end
                    if (rsp.head_deadline !== e.head_deadline)
                    begin
                        $error("head_deadline: expected %h, got %h", e.head_deadline,
                               rsp.head_deadline);
                        errors++;
                    end
                    if (rsp.occupancy !== e.occupancy)
                    begin
                        $error("occupancy: expected %0d, got %0d", e.occupancy, rsp.occupancy);
                        errors++;
                    end
                end
            end
            if (recv_gap > 0)
            begin
                recv_gap <= recv_gap - 1;
                rsp.ready <= 1'b0;
            end
            else
            begin
                rsp.ready <= 1'b1;
                if ($urandom_range(0, 3) == 0)
                    recv_gap <= pick_gap();
            end
        end
    end

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    task automatic add_beat(logic act, logic [63:0] dl, logic [15:0] tag, logic [63:0] now);
        timer_req_t b;
        b.action = act;
        b.deadline = dl;
        b.payload_tag = tag;
        b.counter_now = now;
        pending_beats.push_back(b);
    endtask

    task automatic wait_drained();
        while (pending_beats.size() > 0 || req.valid || expected_rsps.size() > 0)
            @(posedge clk);
    endtask

    task automatic wait_drained_hold();
        while (req.valid || expected_rsps.size() > 0)
            @(posedge clk);
    endtask

    // stimulus
    initial
    begin
        int n;
        int lvl;
        logic [63:0] base;
        errors = 0;
        hold_sender = 1'b0;
        @(posedge rst_n);

        // directed: empty pop, extremes, ties, fill to full, refused insert, partial drain
        add_beat(ACT_EXPIRE, '0, '0, 64'hffff_ffff_ffff_ffff);
        add_beat(ACT_INSERT, 64'hffff_ffff_ffff_ffff, 16'hffff, '0);
        add_beat(ACT_INSERT, '0, 16'h0000, 64'hffff_ffff_ffff_ffff);
        add_beat(ACT_INSERT, 64'd100, 16'h1111, 64'd5);
        add_beat(ACT_INSERT, 64'd100, 16'h2222, 64'd200);
        add_beat(ACT_INSERT, 64'd100, 16'h3333, 64'd100);
        for (int k = 0; k < 11; k++)
            add_beat(ACT_INSERT, 64'd50 + k, 16'(16'h4000 + k), 64'd7);
        add_beat(ACT_INSERT, 64'd1, 16'hdead, 64'd0);
        for (int k = 0; k < 7; k++)
            add_beat(ACT_EXPIRE, rand64(), 16'($urandom()), 64'h8000_0000_0000_0000 + k);
        wait_drained();

        // random: bursts of inserts and expires, clustered deadlines for ties
        n = 0;
        base = rand64();
        while (n < 430)
        begin
            lvl = $urandom_range(1, 20);
            for (int k = 0; k < lvl; k++)
            begin
                logic [63:0] dl;
                dl = ($urandom_range(0, 3) == 0) ? rand64() : base + $urandom_range(0, 15);
                add_beat(ACT_INSERT, dl, 16'($urandom()), rand64());
            end
            n = n + lvl;
            lvl = $urandom_range(1, 20);
            for (int k = 0; k < lvl; k++)
                add_beat(ACT_EXPIRE, rand64(), 16'($urandom()),
                         ($urandom_range(0, 1) == 0) ? base : rand64());
            n = n + lvl;
            if ($urandom_range(0, 4) == 0)
                base = rand64();
            if (n > 200 && n <= 240)
            begin
                // let in-flight beats drain before the next burst
                hold_sender = 1'b1;
                wait_drained_hold();
                hold_sender = 1'b0;
            end
        end
        wait_drained();
        repeat (60) @(posedge clk);
        if (errors == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

    // timeout
    initial
    begin
        #4000000;
        $display("testbench: done, errors");
        $finish;
    end

endmodule
